/* sv/bbl_pkg.sv */
package bbl_pkg;

   localparam int COEF_W    = 21;
   localparam int CSR_W     = 63;
   localparam int LUM_W     = 10;

   localparam logic [LUM_W-1:0] LUM_MAX        = 10'h3FF;
   localparam logic [9:0]       PWM_OFF_PERIOD = 10'd511;
   localparam logic [9:0]       CEIL_RESET     = 10'd512;

   // long division of the target term by the pwm period plus one
   localparam int DIV_STAGES  = 8;
   localparam int DIV_STEPS   = 8;
   // square root, one result bit per step
   localparam int SQRT_STAGES = 16;
   localparam int SQRT_STEPS  = 2;
   // final division by 2a, ten quotient bits
   localparam int QD_STAGES   = 2;
   localparam int QD_STEPS    = 5;

   typedef enum logic [1:0] {
      CSR_BOTTOM     = 2'd0,
      CSR_TOP_FLAT   = 2'd1,
      CSR_TOP_STEREO = 2'd2,
      CSR_CEILING    = 2'd3
   } csr_index_type;

endpackage

/* sv/backlight_brightness_to_luminance.sv */
// throughput: one word per cycle; the pipeline holds while the output skid is full
// the depth comes from the 64-step period divider (8 steps a stage) and the
// 32-step square root (2 steps a stage)
// synchronous active-high reset clears valids, coefficients to zero, ceiling to 512
module backlight_brightness_to_luminance (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_top_screen,
   input  logic                   req_stereo_mode,
   input  logic [9:0]             req_raw_brightness,
   input  logic                   req_pwm_enabled,
   input  logic [9:0]             req_pwm_period,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [9:0]             rsp_luminance,
   output logic                   rsp_root_invalid,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bbl_pkg::csr_index_type csr_index,
   input  logic [62:0]            csr_data
);
   import bbl_pkg::*;

   // configuration
   logic [CSR_W-1:0] coef_bottom_ff, coef_flat_ff, coef_stereo_ff;
   logic [9:0]       ceil_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_bottom_ff <= '0;
         coef_flat_ff   <= '0;
         coef_stereo_ff <= '0;
         ceil_ff        <= CEIL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BOTTOM:     coef_bottom_ff <= csr_data;
            CSR_TOP_FLAT:   coef_flat_ff   <= csr_data;
            CSR_TOP_STEREO: coef_stereo_ff <= csr_data;
            CSR_CEILING:    ceil_ff        <= csr_data[9:0];
         endcase
      end
   end

   logic skid_valid_ff;
   logic adv;
   logic accept;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   // stage 1: coefficient select, period, brightness times ceiling
   logic [CSR_W-1:0]         set_sel;
   logic                     v1_ff;
   logic signed [COEF_W-1:0] a1_ff, b1_ff, c1_ff;
   logic [10:0]              d1_ff, d1_in;
   logic [19:0]              rm1_ff, rm1_in;

   always_comb begin
      if (req_top_screen) begin
         set_sel = req_stereo_mode ? coef_stereo_ff : coef_flat_ff;
      end else begin
         set_sel = coef_bottom_ff;
      end
      d1_in  = {1'b0, (req_pwm_enabled ? req_pwm_period : PWM_OFF_PERIOD)} + 11'd1;
      rm1_in = req_raw_brightness * ceil_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= $signed(set_sel[62:42]);
         b1_ff  <= $signed(set_sel[41:21]);
         c1_ff  <= $signed(set_sel[20:0]);
         d1_ff  <= d1_in;
         rm1_ff <= rm1_in;
      end
   end

   // stage 2: products
   logic                     v2_ff;
   logic signed [41:0]       bb2_ff, ac2_ff, arm2_ff;
   logic signed [COEF_W-1:0] a2_ff, b2_ff;
   logic [10:0]              d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bb2_ff  <= b1_ff * b1_ff;
         ac2_ff  <= a1_ff * c1_ff;
         arm2_ff <= a1_ff * $signed({1'b0, rm1_ff});
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         d2_ff   <= d1_ff;
      end
   end

   // stage 3 / divider: e = 1024*b*b - 8*a*c + floor(2^21*a*r*m / d)
   logic                     dv_v_ff    [0:DIV_STAGES];
   logic [10:0]              dv_rem_ff  [0:DIV_STAGES];
   logic [63:0]              dv_work_ff [0:DIV_STAGES];
   logic signed [63:0]       dv_k_ff    [0:DIV_STAGES];
   logic                     dv_neg_ff  [0:DIV_STAGES];
   logic signed [COEF_W-1:0] dv_a_ff    [0:DIV_STAGES];
   logic signed [COEF_W-1:0] dv_b_ff    [0:DIV_STAGES];
   logic [10:0]              dv_d_ff    [0:DIV_STAGES];
   logic [10:0]              dv_rem_in  [1:DIV_STAGES];
   logic [63:0]              dv_work_in [1:DIV_STAGES];

   logic signed [63:0] k3_in;
   logic [41:0]        mag3_in;

   always_comb begin
      k3_in   = (64'(bb2_ff) <<< 10) - (64'(ac2_ff) <<< 3);
      mag3_in = arm2_ff[41] ? 42'(-arm2_ff) : 42'(arm2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= '0;
         dv_work_ff[0] <= {2'b00, mag3_in[40:0], 21'b0};
         dv_k_ff[0]    <= k3_in;
         dv_neg_ff[0]  <= arm2_ff[41];
         dv_a_ff[0]    <= a2_ff;
         dv_b_ff[0]    <= b2_ff;
         dv_d_ff[0]    <= d2_ff;
      end
   end

   for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
      always_comb begin
         logic [11:0] trial;
         logic [10:0] rem;
         logic [63:0] work;
         rem  = dv_rem_ff[i-1];
         work = dv_work_ff[i-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem, work[63]};
            work  = {work[62:0], 1'b0};
            if (trial >= {1'b0, dv_d_ff[i-1]}) begin
               rem     = 11'(trial - {1'b0, dv_d_ff[i-1]});
               work[0] = 1'b1;
            end else begin
               rem = trial[10:0];
            end
         end
         dv_rem_in[i]  = rem;
         dv_work_in[i] = work;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[i] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[i] <= dv_v_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[i]  <= dv_rem_in[i];
            dv_work_ff[i] <= dv_work_in[i];
            dv_k_ff[i]    <= dv_k_ff[i-1];
            dv_neg_ff[i]  <= dv_neg_ff[i-1];
            dv_a_ff[i]    <= dv_a_ff[i-1];
            dv_b_ff[i]    <= dv_b_ff[i-1];
            dv_d_ff[i]    <= dv_d_ff[i-1];
         end
      end
   end

   // floor of the signed quotient
   logic                     f1_v_ff;
   logic signed [63:0]       f1_fl_ff, f1_k_ff;
   logic signed [COEF_W-1:0] f1_a_ff, f1_b_ff;
   logic [63:0]              f1_adj;

   assign f1_adj = dv_work_ff[DIV_STAGES] + 64'(dv_rem_ff[DIV_STAGES] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (adv) begin
         f1_v_ff <= dv_v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_fl_ff <= dv_neg_ff[DIV_STAGES] ? -$signed(f1_adj)
                                           : $signed(dv_work_ff[DIV_STAGES]);
         f1_k_ff  <= dv_k_ff[DIV_STAGES];
         f1_a_ff  <= dv_a_ff[DIV_STAGES];
         f1_b_ff  <= dv_b_ff[DIV_STAGES];
      end
   end

   // square root of e, with invalid flag formed alongside
   logic                     sq_v_ff    [0:SQRT_STAGES];
   logic [33:0]              sq_rem_ff  [0:SQRT_STAGES];
   logic [31:0]              sq_root_ff [0:SQRT_STAGES];
   logic [63:0]              sq_x_ff    [0:SQRT_STAGES];
   logic signed [COEF_W-1:0] sq_a_ff    [0:SQRT_STAGES];
   logic signed [COEF_W-1:0] sq_b_ff    [0:SQRT_STAGES];
   logic                     sq_inv_ff  [0:SQRT_STAGES];
   logic [33:0]              sq_rem_in  [1:SQRT_STAGES];
   logic [31:0]              sq_root_in [1:SQRT_STAGES];
   logic [63:0]              sq_x_in    [1:SQRT_STAGES];

   logic signed [63:0] e_in;

   assign e_in = f1_k_ff + f1_fl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_x_ff[0]    <= e_in;
         sq_a_ff[0]    <= f1_a_ff;
         sq_b_ff[0]    <= f1_b_ff;
         sq_inv_ff[0]  <= (f1_a_ff == '0) || e_in[63];
      end
   end

   for (genvar i = 1; i <= SQRT_STAGES; i++) begin : g_sqrt
      always_comb begin
         logic [35:0] r2;
         logic [35:0] trial;
         logic [33:0] rem;
         logic [31:0] root;
         logic [63:0] x;
         rem  = sq_rem_ff[i-1];
         root = sq_root_ff[i-1];
         x    = sq_x_ff[i-1];
         for (int j = 0; j < SQRT_STEPS; j++) begin
            r2    = {rem, x[63:62]};
            x     = {x[61:0], 2'b00};
            trial = {2'b00, root, 2'b01};
            if (r2 >= trial) begin
               rem  = 34'(r2 - trial);
               root = {root[30:0], 1'b1};
            end else begin
               rem  = r2[33:0];
               root = {root[30:0], 1'b0};
            end
         end
         sq_rem_in[i]  = rem;
         sq_root_in[i] = root;
         sq_x_in[i]    = x;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[i] <= sq_v_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[i]  <= sq_rem_in[i];
            sq_root_ff[i] <= sq_root_in[i];
            sq_x_ff[i]    <= sq_x_in[i];
            sq_a_ff[i]    <= sq_a_ff[i-1];
            sq_b_ff[i]    <= sq_b_ff[i-1];
            sq_inv_ff[i]  <= sq_inv_ff[i-1];
         end
      end
   end

   // numerator 16*(s - 32b) + a
   logic                     p1_v_ff, p1_inv_ff;
   logic signed [39:0]       p1_num_ff, p1_num_in;
   logic signed [33:0]       p1_n;
   logic signed [COEF_W-1:0] p1_a_ff;

   always_comb begin
      p1_n      = $signed({2'b00, sq_root_ff[SQRT_STAGES]})
                  - (34'(sq_b_ff[SQRT_STAGES]) <<< 5);
      p1_num_in = (40'(p1_n) <<< 4) + 40'(sq_a_ff[SQRT_STAGES]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= sq_v_ff[SQRT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_num_ff <= p1_num_in;
         p1_a_ff   <= sq_a_ff[SQRT_STAGES];
         p1_inv_ff <= sq_inv_ff[SQRT_STAGES];
      end
   end

   // make the divisor positive
   logic               p2_v_ff, p2_inv_ff;
   logic signed [39:0] p2_num_ff;
   logic [21:0]        p2_den_ff;
   logic [21:0]        p2_amag;

   assign p2_amag = p1_a_ff[COEF_W-1] ? 22'(-(22'(p1_a_ff))) : 22'(p1_a_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (adv) begin
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_num_ff <= p1_a_ff[COEF_W-1] ? -p1_num_ff : p1_num_ff;
         p2_den_ff <= {p2_amag[20:0], 1'b0};
         p2_inv_ff <= p1_inv_ff;
      end
   end

   // range checks, then ten quotient bits
   logic        qd_v_ff   [0:QD_STAGES];
   logic [21:0] qd_rem_ff [0:QD_STAGES];
   logic [9:0]  qd_low_ff [0:QD_STAGES];
   logic [21:0] qd_den_ff [0:QD_STAGES];
   logic        qd_inv_ff [0:QD_STAGES];
   logic        qd_neg_ff [0:QD_STAGES];
   logic        qd_sat_ff [0:QD_STAGES];
   logic [21:0] qd_rem_in [1:QD_STAGES];
   logic [9:0]  qd_low_in [1:QD_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         qd_v_ff[0] <= 1'b0;
      end else if (adv) begin
         qd_v_ff[0] <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qd_rem_ff[0] <= p2_num_ff[31:10];
         qd_low_ff[0] <= p2_num_ff[9:0];
         qd_den_ff[0] <= p2_den_ff;
         qd_inv_ff[0] <= p2_inv_ff;
         qd_neg_ff[0] <= p2_num_ff[39];
         qd_sat_ff[0] <= !p2_num_ff[39]
                         && (p2_num_ff[38:0] >= {7'b0, p2_den_ff, 10'b0});
      end
   end

   for (genvar i = 1; i <= QD_STAGES; i++) begin : g_qdiv
      always_comb begin
         logic [22:0] trial;
         logic [21:0] rem;
         logic [9:0]  low;
         rem = qd_rem_ff[i-1];
         low = qd_low_ff[i-1];
         for (int j = 0; j < QD_STEPS; j++) begin
            trial = {rem, low[9]};
            low   = {low[8:0], 1'b0};
            if (trial >= {1'b0, qd_den_ff[i-1]}) begin
               rem    = 22'(trial - {1'b0, qd_den_ff[i-1]});
               low[0] = 1'b1;
            end else begin
               rem = trial[21:0];
            end
         end
         qd_rem_in[i] = rem;
         qd_low_in[i] = low;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qd_v_ff[i] <= 1'b0;
         end else if (adv) begin
            qd_v_ff[i] <= qd_v_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            qd_rem_ff[i] <= qd_rem_in[i];
            qd_low_ff[i] <= qd_low_in[i];
            qd_den_ff[i] <= qd_den_ff[i-1];
            qd_inv_ff[i] <= qd_inv_ff[i-1];
            qd_neg_ff[i] <= qd_neg_ff[i-1];
            qd_sat_ff[i] <= qd_sat_ff[i-1];
         end
      end
   end

   // final clamp
   logic             fn_v_ff, fn_inv_ff;
   logic [LUM_W-1:0] fn_lum_ff, fn_lum_in;

   always_comb begin
      priority if (qd_inv_ff[QD_STAGES] || qd_neg_ff[QD_STAGES]) begin
         fn_lum_in = '0;
      end else if (qd_sat_ff[QD_STAGES]) begin
         fn_lum_in = LUM_MAX;
      end else begin
         fn_lum_in = qd_low_ff[QD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fn_v_ff <= 1'b0;
      end else if (adv) begin
         fn_v_ff <= qd_v_ff[QD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fn_lum_ff <= fn_lum_in;
         fn_inv_ff <= qd_inv_ff[QD_STAGES];
      end
   end

   // output register with skid word
   logic             rsp_valid_ff, rsp_inv_ff, skid_inv_ff;
   logic [LUM_W-1:0] rsp_lum_ff, skid_lum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_lum_ff    <= skid_lum_ff;
            rsp_inv_ff    <= skid_inv_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_ready) begin
         if (fn_v_ff) begin
            skid_lum_ff   <= fn_lum_ff;
            skid_inv_ff   <= fn_inv_ff;
            skid_valid_ff <= 1'b1;
         end
      end else begin
         rsp_valid_ff <= fn_v_ff;
         rsp_lum_ff   <= fn_lum_ff;
         rsp_inv_ff   <= fn_inv_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luminance    = rsp_lum_ff;
   assign rsp_root_invalid = rsp_inv_ff;

endmodule

/* verif/tb_backlight_brightness_to_luminance.sv */
module tb_backlight_brightness_to_luminance;
   import bbl_pkg::*;

   typedef struct {
      logic       top_screen;
      logic       stereo_mode;
      logic [9:0] raw_brightness;
      logic       pwm_enabled;
      logic [9:0] pwm_period;
   } bright_word_type;

   typedef struct {
      logic [9:0] luminance;
      logic       root_invalid;
   } lum_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_top_screen = 0;
   logic req_stereo_mode = 0;
   logic [9:0] req_raw_brightness = '0;
   logic req_pwm_enabled = 0;
   logic [9:0] req_pwm_period = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [9:0] rsp_luminance;
   logic rsp_root_invalid;
   logic csr_valid = 0;
   logic csr_ready;
   csr_index_type csr_index = CSR_BOTTOM;
   logic [62:0] csr_data = '0;

   bright_word_type pending_words[$];
   lum_word_type expected_lum[$];
   logic [62:0] coeff_set[3];
   logic [9:0] ceiling;
   logic req_taken = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int checked = 0;
   int invalid_seen = 0;
   int clamped_seen = 0;

   backlight_brightness_to_luminance DUT (.*);

   always #2 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   function automatic longint floor_quot(longint num, longint den);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   function automatic lum_word_type solve_luminance(bright_word_type w);
      logic [62:0] sel;
      longint a, b, c, d, m, r, q, e, s, n, l;
      lum_word_type res;
      if (w.top_screen) sel = w.stereo_mode ? coeff_set[CSR_TOP_STEREO] : coeff_set[CSR_TOP_FLAT];
      else sel = coeff_set[CSR_BOTTOM];
      a = $signed(sel[62:42]);
      b = $signed(sel[41:21]);
      c = $signed(sel[20:0]);
      d = longint'(w.pwm_enabled ? w.pwm_period : PWM_OFF_PERIOD) + 1;
      m = longint'(ceiling);
      r = longint'(w.raw_brightness);
      q = b * b * 512 * d - 4 * a * (c * d - r * m * 262144);
      res.luminance = '0;
      res.root_invalid = 1;
      if (a == 0 || q < 0) return res;
      e = (2 * q) / d;
      s = longint'(int_sqrt(longint'(e)));
      n = s - 32 * b;
      l = floor_quot(16 * n + a, 2 * a);
      if (l < 0) l = 0;
      if (l > 1023) l = 1023;
      res.luminance = l[9:0];
      res.root_invalid = 0;
      return res;
   endfunction

   function automatic logic [62:0] pack_coeffs(int a, int b, int c);
      logic [20:0] fa, fb, fc;
      fa = a[20:0];
      fb = b[20:0];
      fc = c[20:0];
      return {fa, fb, fc};
   endfunction

   // driver
   always @(negedge clock) begin
      bright_word_type w;
      logic send;
      send = req_valid && !req_taken;
      if (!reset && !send && pending_words.size() > 0
            && $urandom_range(99) >= send_gap_pct) begin
         w = pending_words.pop_front();
         req_top_screen <= w.top_screen;
         req_stereo_mode <= w.stereo_mode;
         req_raw_brightness <= w.raw_brightness;
         req_pwm_enabled <= w.pwm_enabled;
         req_pwm_period <= w.pwm_period;
         send = 1;
      end
      req_valid <= send;
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      bright_word_type w;
      lum_word_type x;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         w.top_screen = req_top_screen;
         w.stereo_mode = req_stereo_mode;
         w.raw_brightness = req_raw_brightness;
         w.pwm_enabled = req_pwm_enabled;
         w.pwm_period = req_pwm_period;
         expected_lum.push_back(solve_luminance(w));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lum.size() == 0) begin
            $error("result word with nothing expected");
            failures++;
         end else begin
            x = expected_lum.pop_front();
            checked++;
            if (x.root_invalid) invalid_seen++;
            else if (x.luminance == 0 || x.luminance == LUM_MAX) clamped_seen++;
            if (rsp_luminance !== x.luminance) begin
               $error("luminance expected %0d actual %0d", x.luminance, rsp_luminance);
               failures++;
            end
            if (rsp_root_invalid !== x.root_invalid) begin
               $error("root_invalid expected %0d actual %0d", x.root_invalid,
                      rsp_root_invalid);
               failures++;
            end
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [62:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CEILING) ceiling = val[9:0];
      else coeff_set[idx] = val;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // a word held on the input by the driver is still in flight
   task automatic drain;
      while (pending_words.size() != 0 || req_valid || expected_lum.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic int rand_signed21();
      return int'($urandom_range(2097151)) - 1048576;
   endfunction

   function automatic bright_word_type random_word();
      bright_word_type w;
      w.top_screen = 1'($urandom_range(1));
      w.stereo_mode = 1'($urandom_range(1));
      w.pwm_enabled = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: w.pwm_period = 10'($urandom_range(15));
         1: w.pwm_period = 10'(1023 - $urandom_range(15));
         default: w.pwm_period = 10'($urandom_range(1023));
      endcase
      w.raw_brightness = $urandom_range(1) ? 10'($urandom_range(1023))
                                           : 10'($urandom_range(63));
      return w;
   endfunction

   initial begin
      bright_word_type w;
      coeff_set[0] = '0;
      coeff_set[1] = '0;
      coeff_set[2] = '0;
      ceiling = CEIL_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // zero leading coefficient, plausible curve, and a curve whose discriminant is negative at zero brightness
      write_csr(CSR_BOTTOM, pack_coeffs(0, 78643, 524288));
      write_csr(CSR_TOP_FLAT, pack_coeffs(94000, 78643, 100000));
      write_csr(CSR_TOP_STEREO, pack_coeffs(1048575, 0, 1048575));
      for (int sc = 0; sc < 3; sc++)
         for (int k = 0; k < 8; k++) begin
            w.top_screen = (sc != 0);
            w.stereo_mode = (sc == 2);
            w.raw_brightness = k[0] ? 10'd1023 : 10'd0;
            w.pwm_enabled = k[1];
            w.pwm_period = k[2] ? 10'd1023 : 10'd0;
            pending_words.push_back(w);
         end
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 55; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 55; end
            default: begin send_gap_pct = 8; stall_pct = 8; end
         endcase
         case (ph)
            0: begin
               write_csr(CSR_BOTTOM, pack_coeffs(120000, 60000, -20000));
               write_csr(CSR_TOP_FLAT, pack_coeffs(2000, 10000, 0));
               write_csr(CSR_TOP_STEREO, pack_coeffs(-500000, 900000, 300000));
               write_csr(CSR_CEILING, 63'(1023));
            end
            1: begin
               write_csr(CSR_BOTTOM, {63{1'b1}});
               write_csr(CSR_TOP_FLAT, pack_coeffs(1048575, -1048576, -1048576));
               write_csr(CSR_TOP_STEREO, pack_coeffs(-1048576, 1048575, 1048575));
               write_csr(CSR_CEILING, 63'(1));
            end
            2: write_csr(CSR_CEILING, 63'(0));
            default: begin
               write_csr(CSR_BOTTOM, pack_coeffs(rand_signed21(), rand_signed21(),
                                                 rand_signed21()));
               write_csr(CSR_TOP_FLAT, pack_coeffs($urandom_range(200000),
                                                   rand_signed21(), rand_signed21()));
               write_csr(CSR_TOP_STEREO, 63'({$urandom, $urandom}));
               write_csr(CSR_CEILING, 63'($urandom_range(1023)));
            end
         endcase
         repeat (120) pending_words.push_back(random_word());
         drain();
      end

      $display("checked %0d luminance words over 7 coefficient settings and 4 handshake modes",
               checked);
      $display("%0d flagged invalid, %0d saturated or zero", invalid_seen, clamped_seen);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule
